@@ hw/rtl/qstg_pkg.sv @@
// qstg_pkg: shared types, constants and the sine table for the queued tone generator
// no dependencies; used by qstg_queue, qstg_sine and queued_sine_tone_generator_top
`default_nettype none

package qstg_pkg;

  localparam int unsigned SAMPLE_RATE     = 44100;
  localparam int unsigned SINE_TABLE_SIZE = 1024;
  localparam int unsigned QUARTER         = SINE_TABLE_SIZE / 4;

  localparam int unsigned AMP_W     = 15;
  localparam int unsigned PHASE_W   = 16;
  localparam int unsigned LEFT_W    = 22;
  localparam int unsigned LEVEL_W   = 5;
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned IDX_W     = $clog2(SINE_TABLE_SIZE);
  localparam int unsigned ROM_AW    = $clog2(QUARTER + 1);
  localparam int unsigned PROD_W    = 2 * AMP_W;

  localparam logic [AMP_W-1:0] AMP_RESET = 15'd28000;

  // samples per ms split as whole part plus tenths (44.1 per ms)
  localparam int unsigned SAMPLES_PER_MS = SAMPLE_RATE / 1000;
  localparam int unsigned DIV10_MUL      = 52429;
  localparam int unsigned DIV10_SHIFT    = 19;

  // idx = phase * SINE_TABLE_SIZE / SAMPLE_RATE by reciprocal multiply, exact for phase < rate
  localparam int unsigned IDX_SHIFT  = 31;
  localparam longint unsigned IDX_MUL =
    ((64'(SINE_TABLE_SIZE) << IDX_SHIFT) + 64'(SAMPLE_RATE) - 64'd1) / 64'(SAMPLE_RATE);
  localparam int unsigned IDX_MUL_W  = 26;
  localparam int unsigned IDX_PROD_W = PHASE_W + IDX_MUL_W;

  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

  typedef enum logic {
    OP_TICK    = 1'b0,
    OP_ENQUEUE = 1'b1
  } op_e;

  typedef struct packed {
    op_e         operation;
    logic [15:0] tone_freq;
    logic [15:0] duration_ms;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       accepted;
    logic                       playing;
    logic [LEVEL_W-1:0]         queue_level;
  } out_word_t;

  // one queue entry: phase step already reduced modulo the rate, samples remaining
  typedef struct packed {
    logic [PHASE_W-1:0] step;
    logic [LEFT_W-1:0]  left;
  } q_entry_t;

  // per-item control from the queue stage into the sample pipeline
  typedef struct packed {
    logic               valid;
    logic               playing;
    logic               accepted;
    logic [LEVEL_W-1:0] queue_level;
    logic [PHASE_W-1:0] phase;
  } ctrl_t;

  typedef logic [AMP_W-1:0] sine_rom_t [QUARTER+1];

  // q30 taylor series of sin(pi/2 * k / QUARTER), rounded to q15
  function automatic logic [AMP_W-1:0] sine_q15(input int unsigned k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned r;
    longint          sum;
    x    = (PI_HALF_Q30 * 64'(k)) / QUARTER;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd210;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd272;
    sum  = sum + longint'(term);
    if (sum < 0) begin
      sum = 0;
    end
    r = (64'(sum) + 64'd16384) >> 15;
    if (r > 64'd32767) begin
      r = 64'd32767;
    end
    return AMP_W'(r);
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int unsigned k = 0; k <= QUARTER; k++) begin
      rom[k] = sine_q15(k);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

`default_nettype wire

@@ hw/rtl/queued_sine_tone_generator_top.sv @@
// queued_sine_tone_generator_top: top level of the queued sine tone generator
// depends on qstg_pkg, qstg_queue and qstg_sine
`default_nettype none

// usage
//   input channel (in_valid_i / in_ready_o / in_word_i): each word is either an
//   enqueue (frequency in Hz, duration in ms) or a sample tick
//   output channel (out_valid_o / out_ready_i / out_word_o): exactly one word per
//   input word, in order: the sample and playing flag for a tick, the accepted
//   flag for an enqueue, and the queue level after the word in both cases
//   cfg_we_i / cfg_wdata_i write the 15-bit amplitude; write it only while idle
// throughput: one word per cycle unless the output stalls; the head entry
//   of the queue memory is prefetched every cycle (read address = next head,
//   write bypassed into the read register), so consecutive ticks on the
//   same tone need no interlock
// the sine path runs as four registered steps behind the queue stage:
//   table index by reciprocal multiply, quarter-wave table, amplitude multiply,
//   sign and rounding into the output register
// stall: all stages move together; while the output word is held, in_ready_o
//   drops and nothing advances
// reset: queue empty, phase zero, amplitude 28000, no output word pending;
//   queue memory is not cleared and needs no clearing pass

module queued_sine_tone_generator_top #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire qstg_pkg::in_word_t         in_word_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output qstg_pkg::out_word_t             out_word_o,
  input  wire logic                       cfg_we_i,
  input  wire logic [qstg_pkg::AMP_W-1:0] cfg_wdata_i
);

  logic [qstg_pkg::AMP_W-1:0] amp_q;
  logic                       en;
  logic                       out_valid;
  qstg_pkg::ctrl_t            ctrl;

  // global advance: output register empty or being drained
  assign en         = !out_valid || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amp_q <= qstg_pkg::AMP_RESET;
    end else if (cfg_we_i) begin
      amp_q <= cfg_wdata_i;
    end
  end

  // queue stage: memory, pointers, count, phase
  qstg_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .in_valid_i (in_valid_i),
    .in_word_i  (in_word_i),
    .ctrl_o     (ctrl)
  );

  // sample pipeline and output register
  qstg_sine u_sine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .amplitude_i (amp_q),
    .ctrl_i      (ctrl),
    .out_valid_o (out_valid),
    .out_word_o  (out_word_o)
  );

  assign out_valid_o = out_valid;

`ifndef SYNTHESIS
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready_i) |-> !in_ready_o)
    else $error("input taken while output stalled");

  a_word_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready_i) |=> out_valid && $stable(out_word_o))
    else $error("stalled output word changed");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/qstg_queue.sv @@
// qstg_queue: tone queue memory, head/tail/count and phase accumulator
// depends on qstg_pkg
`default_nettype none

module qstg_queue #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             in_valid_i,
  input  wire qstg_pkg::in_word_t in_word_i,
  output qstg_pkg::ctrl_t       ctrl_o
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QUEUE_DEPTH);

  qstg_pkg::q_entry_t mem_q [QUEUE_DEPTH];
  qstg_pkg::q_entry_t rd_q;

  logic [PtrW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0] count_q, count_d;
  logic [qstg_pkg::PHASE_W-1:0] phase_q, phase_d;
  qstg_pkg::ctrl_t ctrl_q;

  logic do_item, is_enq, enq_ok, tick_ok, pop;
  logic we;
  logic [PtrW-1:0] waddr;
  qstg_pkg::q_entry_t wdata;
  logic [31:0] dur_div_prod;
  logic [qstg_pkg::LEFT_W-1:0] dur_ticks;
  logic [qstg_pkg::PHASE_W-1:0] freq_step;
  logic [qstg_pkg::PHASE_W:0] phase_sum;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == LastPtr) ? '0 : p + PtrW'(1);
  endfunction

  assign do_item = in_valid_i && en_i;
  assign is_enq  = (in_word_i.operation == qstg_pkg::OP_ENQUEUE);

  // duration in samples: dur*44 + dur/10
  assign dur_div_prod = 32'(in_word_i.duration_ms) * 32'(qstg_pkg::DIV10_MUL);
  assign dur_ticks = qstg_pkg::LEFT_W'(in_word_i.duration_ms) *
                     qstg_pkg::LEFT_W'(qstg_pkg::SAMPLES_PER_MS)
                   + qstg_pkg::LEFT_W'(dur_div_prod >> qstg_pkg::DIV10_SHIFT);

  // frequency below twice the rate, one subtract reduces it
  assign freq_step = (32'(in_word_i.tone_freq) >= qstg_pkg::SAMPLE_RATE)
                   ? in_word_i.tone_freq - qstg_pkg::PHASE_W'(qstg_pkg::SAMPLE_RATE)
                   : in_word_i.tone_freq;

  // zero-length tone only when duration is zero
  assign enq_ok  = do_item && is_enq && (in_word_i.duration_ms != '0) && (count_q != FullCnt);
  assign tick_ok = do_item && !is_enq && (count_q != '0);
  assign pop     = tick_ok && (rd_q.left <= qstg_pkg::LEFT_W'(1));

  assign phase_sum = (qstg_pkg::PHASE_W + 1)'(phase_q) + (qstg_pkg::PHASE_W + 1)'(rd_q.step);

  always_comb begin
    we    = enq_ok || (tick_ok && !pop);
    waddr = enq_ok ? tail_q : head_q;
    if (enq_ok) begin
      wdata.step = freq_step;
      wdata.left = dur_ticks;
    end else begin
      wdata.step = rd_q.step;
      wdata.left = rd_q.left - qstg_pkg::LEFT_W'(1);
    end
    head_d  = pop ? ptr_inc(head_q) : head_q;
    tail_d  = enq_ok ? ptr_inc(tail_q) : tail_q;
    count_d = count_q + CntW'(enq_ok) - CntW'(pop);
    phase_d = phase_q;
    if (tick_ok) begin
      if (phase_sum >= (qstg_pkg::PHASE_W + 1)'(qstg_pkg::SAMPLE_RATE)) begin
        phase_d = qstg_pkg::PHASE_W'(phase_sum
                  - (qstg_pkg::PHASE_W + 1)'(qstg_pkg::SAMPLE_RATE));
      end else begin
        phase_d = qstg_pkg::PHASE_W'(phase_sum);
      end
    end
  end

  // memory: one write, one prefetch read of the next head with write bypass
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (we && (waddr == head_d)) begin
      rd_q <= wdata;
    end else begin
      rd_q <= mem_q[head_d];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      phase_q <= '0;
      ctrl_q  <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      phase_q <= phase_d;
      if (en_i) begin
        ctrl_q.valid       <= do_item;
        ctrl_q.playing     <= tick_ok;
        ctrl_q.accepted    <= enq_ok;
        ctrl_q.queue_level <= qstg_pkg::LEVEL_W'(count_d);
        ctrl_q.phase       <= phase_q;
      end
    end
  end

  assign ctrl_o = ctrl_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("queue count above depth");

  a_ptrs_meet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0 || count_q == FullCnt) |-> head_q == tail_q)
    else $error("head and tail disagree with count");

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(phase_q) < qstg_pkg::SAMPLE_RATE)
    else $error("phase out of range");

  a_tick_moves_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !tick_ok |=> phase_q == $past(phase_q))
    else $error("phase moved without a tick");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/qstg_sine.sv @@
// qstg_sine: sample pipeline, phase to table index, quarter-wave lookup, amplitude scale
// depends on qstg_pkg
`default_nettype none

module qstg_sine (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          en_i,
  input  wire logic [qstg_pkg::AMP_W-1:0]    amplitude_i,
  input  wire qstg_pkg::ctrl_t               ctrl_i,
  output logic                               out_valid_o,
  output qstg_pkg::out_word_t                out_word_o
);

  typedef struct packed {
    logic                         playing;
    logic                         accepted;
    logic [qstg_pkg::LEVEL_W-1:0] queue_level;
  } tag_t;

  logic s2_valid_q, s3_valid_q, s4_valid_q, out_valid_q;
  tag_t s2_tag_q, s3_tag_q, s4_tag_q;
  logic [qstg_pkg::IDX_W-1:0]  s2_idx_q;
  logic [qstg_pkg::AMP_W-1:0]  s3_mag_q;
  logic                        s3_neg_q, s4_neg_q;
  logic [qstg_pkg::PROD_W-1:0] s4_prod_q;
  qstg_pkg::out_word_t         out_q;

  logic [qstg_pkg::IDX_PROD_W-1:0] idx_prod;
  logic [1:0]                      quad;
  logic [qstg_pkg::ROM_AW-1:0]     rpos, pos;
  logic [qstg_pkg::AMP_W-1:0]      q_int;
  logic [qstg_pkg::SAMPLE_W-1:0]   mag16;
  tag_t                            s1_tag;

  assign s1_tag.playing     = ctrl_i.playing;
  assign s1_tag.accepted    = ctrl_i.accepted;
  assign s1_tag.queue_level = ctrl_i.queue_level;

  assign idx_prod = qstg_pkg::IDX_PROD_W'(ctrl_i.phase)
                  * qstg_pkg::IDX_PROD_W'(qstg_pkg::IDX_MUL);

  // quadrant picks mirroring and sign
  assign quad = s2_idx_q[qstg_pkg::IDX_W-1 -: 2];
  assign rpos = qstg_pkg::ROM_AW'(s2_idx_q[qstg_pkg::IDX_W-3:0]);
  assign pos  = quad[0] ? qstg_pkg::ROM_AW'(qstg_pkg::QUARTER) - rpos : rpos;

  // floor of a negative product rounds the magnitude up
  assign q_int = s4_prod_q[qstg_pkg::PROD_W-1 -: qstg_pkg::AMP_W];
  assign mag16 = qstg_pkg::SAMPLE_W'(q_int)
               + qstg_pkg::SAMPLE_W'(s4_neg_q && (s4_prod_q[qstg_pkg::AMP_W-1:0] != '0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      s2_valid_q  <= ctrl_i.valid;
      s3_valid_q  <= s2_valid_q;
      s4_valid_q  <= s3_valid_q;
      out_valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_tag_q <= s1_tag;
      s2_idx_q <= idx_prod[qstg_pkg::IDX_SHIFT +: qstg_pkg::IDX_W];

      s3_tag_q <= s2_tag_q;
      s3_mag_q <= qstg_pkg::SINE_ROM[pos];
      s3_neg_q <= quad[1];

      s4_tag_q  <= s3_tag_q;
      s4_prod_q <= qstg_pkg::PROD_W'(amplitude_i) * qstg_pkg::PROD_W'(s3_mag_q);
      s4_neg_q  <= s3_neg_q;

      out_q.accepted    <= s4_tag_q.accepted;
      out_q.playing     <= s4_tag_q.playing;
      out_q.queue_level <= s4_tag_q.queue_level;
      if (!s4_tag_q.playing) begin
        out_q.sample <= '0;
      end else if (s4_neg_q) begin
        out_q.sample <= -$signed(mag16);
      end else begin
        out_q.sample <= $signed(mag16);
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

`ifndef SYNTHESIS
  a_silent_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.playing) |-> out_q.sample == '0)
    else $error("nonzero sample without a playing tone");

  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.playing && out_q.accepted))
    else $error("word flagged as both tick and enqueue");
`endif

endmodule

`default_nettype wire
